### rtl/second_chance_page_replacer_defines.svh
// Assertion macros shared by the second-chance page replacer checkers.
`ifndef SECOND_CHANCE_PAGE_REPLACER_DEFINES_SVH
`define SECOND_CHANCE_PAGE_REPLACER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scpr_pkg.sv
// Shared types and constants of the second-chance page replacer.
package scpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int CFG_W          = 4;
  localparam int FAULT_W        = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ROT,
    ST_EVICT,
    ST_FIN
  } scpr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;
    logic look;
    logic take_hit;
    logic take_miss;
    logic take_fill;
    logic rot_step;
    logic rot_issue;
    logic evict;
    logic finish;
  } scpr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit_found;
    logic scan_done;
    logic full;
    logic ref_at_h;
    logic out_free;
  } scpr_stat_t;

endpackage

### rtl/scpr_ifs.sv
// Channel interfaces: page access input, result output, configuration write.
interface scpr_in_if #(
  parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface scpr_out_if #(
  parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF,
  parameter int SLOT_W    = 3,
  parameter int CNT_W     = 4
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [SLOT_W-1:0]           frame_slot;
  logic                        evicted_valid;
  logic [PAGE_BITS-1:0]        evicted_page;
  logic [CNT_W-1:0]            chances_given;
  logic [scpr_pkg::FAULT_W-1:0] fault_total;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output chances_given, output fault_total,
                  input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, input chances_given, input fault_total,
                  output ready);
endinterface

interface scpr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [scpr_pkg::CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

### rtl/scpr_ctrl.sv
// Controller state machine: sequences lookup, fill, rotation and result load.
module scpr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scpr_pkg::scpr_stat_t stat,
  output scpr_pkg::scpr_cmd_t  cmd
);

  scpr_pkg::scpr_state_t state_r;
  scpr_pkg::scpr_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scpr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = scpr_pkg::ST_LOOK;
      end
      scpr_pkg::ST_LOOK: begin
        if (stat.hit_found) begin
          state_nxt = scpr_pkg::ST_FIN;
        end else if (stat.scan_done) begin
          state_nxt = stat.full ? scpr_pkg::ST_ROT : scpr_pkg::ST_FIN;
        end
      end
      scpr_pkg::ST_ROT: begin
        if (!stat.ref_at_h) state_nxt = scpr_pkg::ST_EVICT;
      end
      scpr_pkg::ST_EVICT: begin
        state_nxt = scpr_pkg::ST_FIN;
      end
      scpr_pkg::ST_FIN: begin
        if (stat.out_free) state_nxt = scpr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = scpr_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      scpr_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      scpr_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
        if (stat.hit_found) begin
          cmd.take_hit = 1'b1;
        end else if (stat.scan_done) begin
          cmd.take_miss = 1'b1;
          cmd.take_fill = !stat.full;
        end
      end
      scpr_pkg::ST_ROT: begin
        cmd.rot_step  = stat.ref_at_h;
        cmd.rot_issue = !stat.ref_at_h;
      end
      scpr_pkg::ST_EVICT: begin
        cmd.evict = 1'b1;
      end
      scpr_pkg::ST_FIN: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/scpr_dp.sv
// Datapath: frame memory, reference flags, scan, rotation and result registers.
module scpr_dp #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF,
  parameter int SLOT_W     = 3,
  parameter int CNT_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scpr_pkg::scpr_cmd_t           cmd,
  output scpr_pkg::scpr_stat_t          stat,
  input  logic [PAGE_BITS-1:0]          in_page,
  input  logic                          cfg_we,
  input  logic [scpr_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [SLOT_W-1:0]             out_frame_slot,
  output logic                          out_evicted_valid,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [CNT_W-1:0]              out_chances_given,
  output logic [scpr_pkg::FAULT_W-1:0]  out_fault_total
);

  localparam int CMP_W = (CNT_W > scpr_pkg::CFG_W) ? CNT_W : scpr_pkg::CFG_W;

  logic [scpr_pkg::CFG_W-1:0]   frames_cfg_r;
  logic [CNT_W-1:0]             filled_r;
  logic [SLOT_W-1:0]            head_r;
  logic [scpr_pkg::FAULT_W-1:0] fault_r;
  logic [MAX_FRAMES-1:0]        ref_r;

  logic [PAGE_BITS-1:0]         mem [MAX_FRAMES];
  logic [PAGE_BITS-1:0]         rd_data_r;
  logic                         rd_valid_r;
  logic [SLOT_W-1:0]            rd_idx_r;
  logic [CNT_W-1:0]             issue_idx_r;

  logic [PAGE_BITS-1:0]         page_r;
  logic [SLOT_W-1:0]            h_r;
  logic [CNT_W-1:0]             chances_r;
  logic                         hit_r;
  logic [SLOT_W-1:0]            slot_r;
  logic                         ev_valid_r;
  logic [PAGE_BITS-1:0]         ev_page_r;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [SLOT_W-1:0]            out_slot_r;
  logic                         out_ev_valid_r;
  logic [PAGE_BITS-1:0]         out_ev_page_r;
  logic [CNT_W-1:0]             out_chances_r;
  logic [scpr_pkg::FAULT_W-1:0] out_fault_r;

  logic [CMP_W-1:0]             cap_ext;
  logic [CMP_W-1:0]             filled_ext;
  logic                         issue_ok;
  logic                         hit_found;
  logic [SLOT_W-1:0]            rd_addr;
  logic [SLOT_W-1:0]            wr_addr;
  logic                         mem_we;
  logic [CNT_W-1:0]             h_inc;
  logic [SLOT_W-1:0]            h_nxt;

  // Clamp capacity to 1..MAX_FRAMES and test for full frames
  assign cap_ext    = (frames_cfg_r == '0) ? CMP_W'(1) : CMP_W'(frames_cfg_r);
  assign filled_ext = CMP_W'(filled_r);

  assign issue_ok  = issue_idx_r < filled_r;
  assign hit_found = rd_valid_r && (rd_data_r == page_r);

  // Advance the rotation pointer, wrapping over the filled slots
  assign h_inc = CNT_W'(h_r) + CNT_W'(1);
  assign h_nxt = (h_inc >= filled_r) ? '0 : h_inc[SLOT_W-1:0];

  assign stat.hit_found = hit_found;
  assign stat.scan_done = !issue_ok && !hit_found;
  assign stat.full      = (filled_r == CNT_W'(MAX_FRAMES)) || (filled_ext >= cap_ext);
  assign stat.ref_at_h  = ref_r[h_r];
  assign stat.out_free  = !out_valid_r || out_ready;

  assign rd_addr = cmd.rot_issue ? h_r : issue_idx_r[SLOT_W-1:0];
  assign wr_addr = cmd.take_fill ? filled_r[SLOT_W-1:0] : h_r;
  assign mem_we  = cmd.take_fill || cmd.evict;

  // Frame page memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= page_r;
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= issue_idx_r[SLOT_W-1:0];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= scpr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      frames_cfg_r <= cfg_data;
    end
  end

  // Lookup scan: issue one read a cycle, compare the one before
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      issue_idx_r <= '0;
    end else if (cmd.start) begin
      rd_valid_r  <= 1'b0;
      issue_idx_r <= '0;
    end else begin
      rd_valid_r <= cmd.look && issue_ok;
      if (cmd.look && issue_ok) issue_idx_r <= issue_idx_r + CNT_W'(1);
    end
  end

  // Reference flags: set on hit, clear on fill and on each chance given
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else begin
      if (cmd.take_hit)  ref_r[rd_idx_r] <= 1'b1;
      if (cmd.take_fill) ref_r[filled_r[SLOT_W-1:0]] <= 1'b0;
      if (cmd.rot_step)  ref_r[h_r] <= 1'b0;
    end
  end

  // Residency state: fill count, head pointer, fault counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      head_r   <= '0;
      fault_r  <= '0;
    end else begin
      if (cmd.take_miss && (fault_r != '1)) fault_r <= fault_r + scpr_pkg::FAULT_W'(1);
      if (cmd.take_fill) filled_r <= filled_r + CNT_W'(1);
      if (cmd.evict)     head_r   <= h_nxt;
    end
  end

  // Per-access working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r     <= in_page;
      hit_r      <= 1'b0;
      ev_valid_r <= 1'b0;
      ev_page_r  <= '0;
      chances_r  <= '0;
    end
    if (cmd.take_hit) begin
      hit_r  <= 1'b1;
      slot_r <= rd_idx_r;
    end
    if (cmd.take_fill) slot_r <= filled_r[SLOT_W-1:0];
    if (cmd.take_miss) h_r <= head_r;
    if (cmd.rot_step) begin
      h_r       <= h_nxt;
      chances_r <= chances_r + CNT_W'(1);
    end
    if (cmd.evict) begin
      slot_r     <= h_r;
      ev_valid_r <= 1'b1;
      ev_page_r  <= rd_data_r;
    end
  end

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit_r      <= hit_r;
      out_slot_r     <= slot_r;
      out_ev_valid_r <= ev_valid_r;
      out_ev_page_r  <= ev_page_r;
      out_chances_r  <= chances_r;
      out_fault_r    <= fault_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_chances_given = out_chances_r;
  assign out_fault_total   = out_fault_r;

endmodule

### rtl/second_chance_page_replacer.sv
// Top level of the second-chance page replacer: controller plus datapath.
// Second-chance (clock) page replacement, one page access at a time. Each access first
// scans the resident frames in order through a one-read-per-cycle frame memory. A hit
// ends the scan at the matching slot; a miss with free capacity fills the next slot; a
// miss with all frames full rotates from the head, clearing one set reference bit per
// cycle, and evicts the first frame whose bit is clear. The next access is taken as soon
// as the previous result is loaded into the output register, even while that result
// still waits for the sink; a result that is ready while the previous one is still held
// there waits until the sink takes it. frames_in_use is written over the cfg channel,
// which is always ready; 0 behaves as 1 and values above MAX_FRAMES behave as MAX_FRAMES.
// Lowering it never discards resident pages. No clearing pass runs after reset.
module second_chance_page_replacer #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  scpr_in_if.sink    in_if,
  scpr_out_if.source out_if,
  scpr_cfg_if.sink   cfg_if
);

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

  scpr_pkg::scpr_cmd_t  cmd;
  scpr_pkg::scpr_stat_t stat;
  logic                 in_ready;

  // Configuration writes are always taken
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;

  scpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scpr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .SLOT_W     (SLOT_W),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_page           (in_if.page),
    .cfg_we            (cfg_if.valid),
    .cfg_data          (cfg_if.frames_in_use),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_hit           (out_if.hit),
    .out_frame_slot    (out_if.frame_slot),
    .out_evicted_valid (out_if.evicted_valid),
    .out_evicted_page  (out_if.evicted_page),
    .out_chances_given (out_if.chances_given),
    .out_fault_total   (out_if.fault_total)
  );

endmodule

### rtl/scpr_checker.sv
// Port-level checker for the second-chance page replacer, bound to the top level.
`include "second_chance_page_replacer_defines.svh"

module scpr_checker #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = scpr_pkg::PAGE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit,
  input logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] out_frame_slot,
  input logic                         out_evicted_valid,
  input logic [PAGE_BITS-1:0]         out_evicted_page,
  input logic [$clog2(MAX_FRAMES + 1)-1:0] out_chances_given,
  input logic [scpr_pkg::FAULT_W-1:0] out_fault_total
);

  // A stalled result holds still
  `SCPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_hit, out_frame_slot, out_evicted_valid, out_evicted_page, out_chances_given, out_fault_total}), "result changed while stalled")

  // One access at a time: input closes right after a transaction
  `SCPR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "access accepted while busy")

  // A hit evicts nothing and grants no chances
  `SCPR_ASSERT_NOW(a_hit_clean, out_valid && out_hit, !out_evicted_valid && (out_chances_given == '0), "hit reported eviction")

  // Without an eviction the evicted page reads zero and no chances are given
  `SCPR_ASSERT_NOW(a_no_evict_zero, out_valid && !out_evicted_valid, (out_evicted_page == '0) && (out_chances_given == '0), "stale eviction fields")

endmodule

bind second_chance_page_replacer scpr_checker #(
  .MAX_FRAMES (MAX_FRAMES),
  .PAGE_BITS  (PAGE_BITS)
) u_scpr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_hit           (out_if.hit),
  .out_frame_slot    (out_if.frame_slot),
  .out_evicted_valid (out_if.evicted_valid),
  .out_evicted_page  (out_if.evicted_page),
  .out_chances_given (out_if.chances_given),
  .out_fault_total   (out_if.fault_total)
);

### tb/sv/tb_second_chance_page_replacer.sv
// Testbench for the second-chance page replacer: page access stimulus, prediction, checking.
`timescale 1ns / 1ps

module tb_second_chance_page_replacer;

  localparam int FRAMES        = scpr_pkg::MAX_FRAMES_DEF;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int PHASE_ITEMS   = 183;
  localparam int PRESSURE_AT   = 600;
  localparam int PRESSURE_LEN  = 400;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic        hit;
    logic [2:0]  slot;
    logic        ev_valid;
    logic [15:0] ev_page;
    logic [3:0]  chances;
    logic [15:0] faults;
  } access_outcome_t;

  // Track resident pages and compare outcomes in order
  class replacer_scoreboard;
    logic [15:0]     frame_pages[FRAMES];
    bit              ref_bits[FRAMES];
    int              head;
    int              filled;
    logic [15:0]     faults;
    logic [3:0]      frames_cfg;
    access_outcome_t expected_outcomes[$];
    int              fail_count;
    int              checked;

    function new();
      frames_cfg = scpr_pkg::CFG_RESET;
      head       = 0;
      filled     = 0;
      faults     = '0;
      fail_count = 0;
      checked    = 0;
      foreach (ref_bits[k]) begin
        ref_bits[k]    = 1'b0;
        frame_pages[k] = '0;
      end
    endfunction

    function void set_frames(logic [3:0] v);
      frames_cfg = v;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Apply one access to the resident set and return its outcome
    function access_outcome_t predict_access(logic [15:0] pg);
      access_outcome_t o;
      int cap;
      int n;
      int h;
      bit found;
      o     = '0;
      found = 1'b0;
      cap   = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
      for (int k = 0; k < filled; k++) begin
        if (!found && frame_pages[k] == pg) begin
          found  = 1'b1;
          o.slot = 3'(k);
        end
      end
      if (found) begin
        o.hit             = 1'b1;
        ref_bits[o.slot] = 1'b1;
      end else begin
        if (faults != 16'hFFFF) faults++;
        if (filled < cap) begin
          o.slot = 3'(filled);
          filled++;
        end else begin
          // rotate from the oldest page, clearing set bits until a clear one turns up
          n = (filled == 0) ? 1 : filled;
          h = head % n;
          while (ref_bits[h] && o.chances < n) begin
            ref_bits[h] = 1'b0;
            o.chances++;
            h = (h + 1) % n;
          end
          o.slot     = 3'(h);
          o.ev_valid = 1'b1;
          o.ev_page  = frame_pages[h];
          head       = (h + 1) % n;
        end
        frame_pages[o.slot] = pg;
        ref_bits[o.slot]    = 1'b0;
      end
      o.faults = faults;
      return o;
    endfunction

    function void note_access(logic [15:0] pg);
      expected_outcomes.push_back(predict_access(pg));
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_result(access_outcome_t got);
      access_outcome_t want;
      string diffs;
      checked++;
      if (expected_outcomes.size() == 0) begin
        flag($sformatf("result %0d arrived with no access outstanding", checked));
        return;
      end
      want  = expected_outcomes.pop_front();
      diffs = "";
      if (got.hit !== want.hit) diffs = {diffs, " hit"};
      if (got.slot !== want.slot) diffs = {diffs, " frame_slot"};
      if (got.ev_valid !== want.ev_valid) diffs = {diffs, " evicted_valid"};
      if (got.ev_page !== want.ev_page) diffs = {diffs, " evicted_page"};
      if (got.chances !== want.chances) diffs = {diffs, " chances_given"};
      if (got.faults !== want.faults) diffs = {diffs, " fault_total"};
      if (diffs != "") begin
        flag($sformatf({"result %0d mismatch in%s\n",
                        "  exp hit=%0b slot=%0d evict=%0b/%h chances=%0d faults=%0d\n",
                        "  got hit=%0b slot=%0d evict=%0b/%h chances=%0d faults=%0d"},
                       checked, diffs,
                       want.hit, want.slot, want.ev_valid, want.ev_page, want.chances,
                       want.faults,
                       got.hit, got.slot, got.ev_valid, got.ev_page, got.chances,
                       got.faults));
      end
    endfunction

    function void check_drained();
      if (expected_outcomes.size() != 0)
        flag($sformatf("%0d results never arrived", expected_outcomes.size()));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scpr_in_if  in_ch ();
  scpr_out_if out_ch ();
  scpr_cfg_if cfg_ch ();

  second_chance_page_replacer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  replacer_scoreboard sb = new();

  int          idle_pct     = 0;
  int          results_seen = 0;
  int          cycle_count  = 0;
  int          phase_frames[10] = '{8, 1, 5, 15, 2, 0, 7, 3, 4, 6};
  int          idle_levels[3]   = '{0, 20, 40};

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hold all block inputs at known values from the start
  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.page           <= '0;
    out_ch.ready         <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.frames_in_use <= '0;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    access_outcome_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit      = out_ch.hit;
      got.slot     = out_ch.frame_slot;
      got.ev_valid = out_ch.evicted_valid;
      got.ev_page  = out_ch.evicted_page;
      got.chances  = out_ch.chances_given;
      got.faults   = out_ch.fault_total;
      sb.check_result(got);
      results_seen <= results_seen + 1;
    end
  end

  // Throttle the result side; once, hold off long enough to back up the input
  initial begin
    int  hold_left;
    bit  pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_LEN;
      end
      if (hold_left == 0) hold_left = idle_len();
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one page access and wait for its transaction
  task automatic offer_page(logic [15:0] pg);
    int g;
    g = idle_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.page  <= pg;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_access(pg);
  endtask

  // Drop the input and wait until every outstanding result is out
  task automatic settle_idle(int extra);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write frames_in_use while the block is idle
  task automatic write_frames(logic [3:0] v);
    settle_idle(SETTLE_CYCLES);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.frames_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_frames(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [15:0] pool[12];
    int          pool_n;
    int          cap;
    logic [15:0] pg;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the default three frames, set every bit, then evict with full rotation
    idle_pct = 20;
    offer_page(16'h0000);
    offer_page(16'hFFFF);
    offer_page(16'h0000);
    offer_page(16'h1234);
    offer_page(16'hFFFF);
    offer_page(16'h0000);
    offer_page(16'h1234);
    offer_page(16'h5555);
    offer_page(16'hAAAA);
    offer_page(16'h5555);

    // Lower capacity below the filled count: rotate over all filled frames
    write_frames(4'd1);
    offer_page(16'h0F0F);
    offer_page(16'h1234);
    offer_page(16'hF0F0);

    // Raise capacity past the maximum after the frames are full: append again
    write_frames(4'd15);
    offer_page(16'h8000);
    offer_page(16'h7FFF);
    offer_page(16'h0001);
    offer_page(16'h8000);
    offer_page(16'hC3C3);
    offer_page(16'h3C3C);

    // Capacity zero acts as one
    write_frames(4'd0);
    offer_page(16'h4321);
    offer_page(16'h8000);
    offer_page(16'h9999);

    // Random phases over a page pool around each capacity
    foreach (phase_frames[p]) begin
      write_frames(4'(phase_frames[p]));
      idle_pct = idle_levels[$urandom_range(0, 2)];
      cap      = (phase_frames[p] == 0) ? 1 :
                 (phase_frames[p] > FRAMES) ? FRAMES : phase_frames[p];
      pool_n   = $urandom_range(cap, 10);
      for (int k = 0; k < pool_n; k++) pool[k] = 16'($urandom_range(0, 65535));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) pg = pool[$urandom_range(0, pool_n - 1)];
        else pg = 16'($urandom_range(0, 65535));
        offer_page(pg);
      end
    end

    // Drain and report
    settle_idle(DRAIN_CYCLES);
    sb.check_drained();
    if (sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
